/* design/lrd_pkg.sv */
// Shared constants, payload structs and segment descriptor for the DDA line rasterizer.
package lrd_pkg;

  localparam int COORD_BITS  = 6;
  localparam int FRAC_BITS   = 16;
  localparam int DIV_W       = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int SLOPE_W     = FRAC_BITS + 2;
  localparam int ACC_W       = COORD_BITS + FRAC_BITS + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } seg_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } pixel_out_t;

  typedef struct packed {
    logic                  x_major;
    logic [COORD_BITS-1:0] maj0;
    logic [COORD_BITS-1:0] min0;
    logic [COORD_BITS-1:0] dmaj;
    logic [SLOPE_W-1:0]    slope;
  } seg_desc_t;

endpackage

/* design/lrd_front.sv */
// Segment classification and bit-serial slope division.
module lrd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrd_pkg::seg_in_t  seg_i,
  output logic              push_o,
  input  logic              full_i,
  output lrd_pkg::seg_desc_t desc_o
);
  import lrd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e               state_q, state_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIV_W-1:0]      quo_q, quo_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic                  x_major_q, x_major_d;
  logic [COORD_BITS-1:0] maj0_q, maj0_d;
  logic [COORD_BITS-1:0] min0_q, min0_d;
  logic [COORD_BITS-1:0] dmaj_q, dmaj_d;
  logic                  neg_q, neg_d;

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] adx, ady, dmin_abs;
  logic                  dx_neg, dy_neg, maj_neg, min_neg, xm;
  logic [COORD_BITS:0]   trial;
  logic                  take;
  logic [FRAC_BITS:0]    mag;
  logic [SLOPE_W-1:0]    slope;

  assign dx     = {1'b0, seg_i.x_end} - {1'b0, seg_i.x_start};
  assign dy     = {1'b0, seg_i.y_end} - {1'b0, seg_i.y_start};
  assign dx_neg = dx[COORD_BITS];
  assign dy_neg = dy[COORD_BITS];
  assign adx    = dx_neg ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  assign ady    = dy_neg ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
  assign xm     = adx >= ady;
  assign maj_neg  = xm ? dx_neg : dy_neg;
  assign min_neg  = xm ? dy_neg : dx_neg;
  assign dmin_abs = xm ? ady : adx;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign take  = trial >= {1'b0, dmaj_q};

  assign mag   = quo_q[FRAC_BITS:0] + (FRAC_BITS+1)'(!neg_q && (rem_q != '0));
  assign slope = (dmaj_q == '0) ? '0 :
                 neg_q ? SLOPE_W'(-{1'b0, mag}) : {1'b0, mag};

  assign in_ready_o = state_q == F_IDLE;
  assign push_o     = (state_q == F_PUSH) && !full_i;
  assign desc_o     = '{x_major: x_major_q, maj0: maj0_q, min0: min0_q,
                        dmaj: dmaj_q, slope: slope};

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    x_major_d = x_major_q;
    maj0_d    = maj0_q;
    min0_d    = min0_q;
    dmaj_d    = dmaj_q;
    neg_d     = neg_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          x_major_d = xm;
          dmaj_d    = xm ? adx : ady;
          neg_d     = (dmin_abs != '0) && (maj_neg ^ min_neg);
          if (xm) begin
            maj0_d = dx_neg ? seg_i.x_end : seg_i.x_start;
            min0_d = dx_neg ? seg_i.y_end : seg_i.y_start;
          end else begin
            maj0_d = dy_neg ? seg_i.y_end : seg_i.y_start;
            min0_d = dy_neg ? seg_i.x_end : seg_i.x_start;
          end
          quo_d   = {dmin_abs, {FRAC_BITS{1'b0}}};
          rem_d   = '0;
          cnt_d   = DIV_CNT_W'(DIV_W);
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d = take ? COORD_BITS'(trial - {1'b0, dmaj_q}) : trial[COORD_BITS-1:0];
        quo_d = {quo_q[DIV_W-2:0], take};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    x_major_q <= x_major_d;
    maj0_q    <= maj0_d;
    min0_q    <= min0_d;
    dmaj_q    <= dmaj_d;
    neg_q     <= neg_d;
  end

endmodule

/* design/lrd_fifo.sv */
// Short register queue of segment descriptors between front and back.
module lrd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lrd_pkg::seg_desc_t desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output lrd_pkg::seg_desc_t desc_o
);
  import lrd_pkg::*;

  seg_desc_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign desc_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/lrd_back.sv */
// Pixel stepper: walks the major axis and accumulates the fixed-point minor coordinate.
module lrd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  lrd_pkg::seg_desc_t  desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrd_pkg::pixel_out_t pixel_o
);
  import lrd_pkg::*;

  logic                  busy_q;
  seg_desc_t             desc_q;
  logic [COORD_BITS-1:0] step_q;
  logic [ACC_W-1:0]      acc_q;
  logic                  out_valid_q;
  pixel_out_t            pixel_q;

  logic                  adv, last;
  logic [COORD_BITS+1:0] whole;
  logic [COORD_BITS-1:0] minor, major;

  assign adv   = busy_q && (!out_valid_q || out_ready_i);
  assign last  = step_q == desc_q.dmaj;
  assign pop_o = q_valid_i && (!busy_q || (adv && last));

  assign whole = acc_q[ACC_W-1:FRAC_BITS];
  assign major = desc_q.maj0 + step_q;
  always_comb begin
    if (acc_q[ACC_W-1]) begin
      minor = '0;
    end else if (whole[COORD_BITS+1:COORD_BITS] != 2'b00) begin
      minor = '1;
    end else begin
      minor = whole[COORD_BITS-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (adv && last) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_q.pixel_x    <= desc_q.x_major ? major : minor;
      pixel_q.pixel_y    <= desc_q.x_major ? minor : major;
      pixel_q.last_pixel <= last;
    end
    if (pop_o) begin
      desc_q <= desc_i;
      step_q <= '0;
      acc_q  <= {2'b00, desc_i.min0, 1'b1, {(FRAC_BITS-1){1'b0}}};
    end else if (adv) begin
      step_q <= step_q + 1'b1;
      acc_q  <= acc_q + {{COORD_BITS{desc_q.slope[SLOPE_W-1]}}, desc_q.slope};
    end
  end

endmodule

/* design/line_rasterizer_dda.sv */
// Top level of the DDA line rasterizer.
// Input channel (in_valid_i / in_ready_o / seg_i) takes one segment per transfer
// as two endpoints. Output channel (out_valid_o / out_ready_i / pixel_o) gives
// one pixel per transfer, stepping along the major axis in increasing order;
// last_pixel marks the final pixel of each segment.
// The front classifies a segment and then runs a one-bit-per-cycle restoring
// divider for the slope, COORD_BITS + FRAC_BITS = 22 quotient bits, then hands
// the descriptor to a two-entry queue, waiting while the queue is full. The
// front takes no new segment until it has pushed the descriptor of the last one.
// The back pops a descriptor and emits one pixel per cycle from a registered
// accumulator while the receiver is ready; a segment has at most 64 pixels.
// When the receiver stalls, the output register holds its pixel and the back
// stops; the queue fills and then the front holds in_ready_o low.
// Reset clears the front state, the queue and the output valid; no segment is
// in flight afterward.
module line_rasterizer_dda (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lrd_pkg::seg_in_t    seg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lrd_pkg::pixel_out_t pixel_o
);
  import lrd_pkg::*;

  logic      push, full, pop, q_valid;
  seg_desc_t desc_in, desc_out;

  lrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .seg_i      (seg_i),
    .push_o     (push),
    .full_i     (full),
    .desc_o     (desc_in)
  );

  lrd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (desc_out)
  );

  lrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .desc_i      (desc_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_o     (pixel_o)
  );

endmodule

/* dv/lrd_pixel_monitor.sv */
`timescale 1ns / 1ps
// Monitor for the DDA line rasterizer: predicts the pixels of each segment and checks them.
module lrd_pixel_monitor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  lrd_pkg::seg_in_t    seg_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  lrd_pkg::pixel_out_t pixel_i,
  output int                  err_cnt_o,
  output int                  pend_o
);
  import lrd_pkg::*;

  localparam longint ONE_FRAC  = longint'(1) << FRAC_BITS;
  localparam longint HALF_FRAC = longint'(1) << (FRAC_BITS - 1);
  localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;

  pixel_out_t pending_pixels[$];
  int         mismatch_cnt = 0;

  function automatic void rasterize_seg(input seg_in_t seg);
    longint xa, ya, xb, yb, dx, dy, adx, ady;
    longint maj0, min0, dmaj, dmin, slope, scaled, acc, mnr;
    logic [COORD_BITS-1:0] maj_c, mnr_c;
    bit x_major;
    pixel_out_t px;
    xa = seg.x_start;
    ya = seg.y_start;
    xb = seg.x_end;
    yb = seg.y_end;
    dx = xb - xa;
    dy = yb - ya;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    x_major = (adx >= ady);
    if (x_major) begin
      if (dx < 0) begin
        maj0 = xb; min0 = yb; dmaj = -dx; dmin = -dy;
      end else begin
        maj0 = xa; min0 = ya; dmaj = dx; dmin = dy;
      end
    end else begin
      if (dy < 0) begin
        maj0 = yb; min0 = xb; dmaj = -dy; dmin = -dx;
      end else begin
        maj0 = ya; min0 = xa; dmaj = dy; dmin = dx;
      end
    end
    // round the slope toward +infinity
    if (dmaj == 0) begin
      slope = 0;
    end else begin
      scaled = dmin * ONE_FRAC;
      if (scaled >= 0) slope = (scaled + dmaj - 1) / dmaj;
      else slope = -((-scaled) / dmaj);
    end
    for (longint i = 0; i <= dmaj; i++) begin
      acc = min0 * ONE_FRAC + slope * i + HALF_FRAC;
      if (acc < 0) mnr = 0;
      else mnr = acc / ONE_FRAC;
      if (mnr > COORD_MAX) mnr = COORD_MAX;
      maj_c = COORD_BITS'(maj0 + i);
      mnr_c = COORD_BITS'(mnr);
      px.pixel_x    = x_major ? maj_c : mnr_c;
      px.pixel_y    = x_major ? mnr_c : maj_c;
      px.last_pixel = (i == dmaj);
      pending_pixels.push_back(px);
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_out_t exp_px;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) rasterize_seg(seg_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d last=%0d",
                   $time, pixel_i.pixel_x, pixel_i.pixel_y, pixel_i.last_pixel);
        end else begin
          exp_px = pending_pixels.pop_front();
          if (pixel_i.pixel_x !== exp_px.pixel_x) begin
            mismatch_cnt++;
            $display("%0t: pixel_x mismatch, expected %0d, got %0d",
                     $time, exp_px.pixel_x, pixel_i.pixel_x);
          end
          if (pixel_i.pixel_y !== exp_px.pixel_y) begin
            mismatch_cnt++;
            $display("%0t: pixel_y mismatch, expected %0d, got %0d",
                     $time, exp_px.pixel_y, pixel_i.pixel_y);
          end
          if (pixel_i.last_pixel !== exp_px.last_pixel) begin
            mismatch_cnt++;
            $display("%0t: last_pixel mismatch, expected %0d, got %0d",
                     $time, exp_px.last_pixel, pixel_i.last_pixel);
          end
        end
      end
    end
    err_cnt_o <= mismatch_cnt;
    pend_o    <= pending_pixels.size();
  end

endmodule

/* dv/tb_line_rasterizer_dda.sv */
`timescale 1ns / 1ps
// Testbench top for the DDA line rasterizer: clock, reset, segment stimulus and verdict.
module tb_line_rasterizer_dda;
  import lrd_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RAND_PER_PH  = 160;
  localparam int DRAIN_CYCLES = 100;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  seg_in_t    seg_i       = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  pixel_out_t pixel_o;

  int err_cnt;
  int pend_cnt;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int idle_cycles = 0;
  bit hold_off    = 1'b0;

  line_rasterizer_dda i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .seg_i       (seg_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_o     (pixel_o)
  );

  lrd_pixel_monitor i_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .seg_i       (seg_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_i     (pixel_o),
    .err_cnt_o   (err_cnt),
    .pend_o      (pend_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic seg_in_t mk_seg(input int xs, input int ys, input int xe, input int ye);
    seg_in_t seg;
    seg.x_start = COORD_BITS'(xs);
    seg.y_start = COORD_BITS'(ys);
    seg.x_end   = COORD_BITS'(xe);
    seg.y_end   = COORD_BITS'(ye);
    return seg;
  endfunction

  task automatic send_seg(input seg_in_t seg);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    seg_i      <= seg;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_line_rasterizer_dda: FAIL");
        $finish;
      end
    end
  end

  initial begin
    seg_in_t seg;
    seg_in_t directed_segs[$];
    int xs, ys;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_segs.push_back(mk_seg(0, 0, 0, 0));
    directed_segs.push_back(mk_seg(63, 63, 63, 63));
    directed_segs.push_back(mk_seg(21, 42, 21, 42));
    directed_segs.push_back(mk_seg(0, 0, 63, 0));
    directed_segs.push_back(mk_seg(63, 5, 0, 5));
    directed_segs.push_back(mk_seg(7, 0, 7, 63));
    directed_segs.push_back(mk_seg(9, 63, 9, 0));
    directed_segs.push_back(mk_seg(0, 0, 63, 63));
    directed_segs.push_back(mk_seg(63, 63, 0, 0));
    directed_segs.push_back(mk_seg(0, 63, 63, 0));
    directed_segs.push_back(mk_seg(63, 0, 0, 63));
    directed_segs.push_back(mk_seg(0, 0, 2, 1));
    directed_segs.push_back(mk_seg(0, 1, 2, 0));
    directed_segs.push_back(mk_seg(2, 0, 0, 1));
    directed_segs.push_back(mk_seg(0, 0, 1, 2));
    directed_segs.push_back(mk_seg(1, 0, 0, 2));
    directed_segs.push_back(mk_seg(0, 0, 63, 1));
    directed_segs.push_back(mk_seg(0, 63, 63, 62));
    directed_segs.push_back(mk_seg(0, 0, 1, 63));
    directed_segs.push_back(mk_seg(63, 0, 62, 63));
    directed_segs.push_back(mk_seg(10, 20, 50, 35));
    directed_segs.push_back(mk_seg(50, 35, 10, 20));
    directed_segs.push_back(mk_seg(30, 5, 18, 60));
    directed_segs.push_back(mk_seg(18, 60, 30, 5));

    tx_idle_pct = 37;
    rx_idle_pct = 78;
    foreach (directed_segs[k]) send_seg(directed_segs[k]);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 37;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 37;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_off    = 1'b1;
        end
      endcase
      for (int n = 0; n < RAND_PER_PH; n++) begin
        xs = $urandom_range(63);
        ys = $urandom_range(63);
        seg.x_start = COORD_BITS'(xs);
        seg.y_start = COORD_BITS'(ys);
        // mostly long segments, some short ones to overlap setup and drawing
        if ($urandom_range(9) < 3) begin
          seg.x_end = COORD_BITS'($urandom_range(xs > 5 ? xs - 5 : 0, xs < 58 ? xs + 5 : 63));
          seg.y_end = COORD_BITS'($urandom_range(ys > 5 ? ys - 5 : 0, ys < 58 ? ys + 5 : 63));
        end else begin
          seg.x_end = COORD_BITS'($urandom_range(63));
          seg.y_end = COORD_BITS'($urandom_range(63));
        end
        send_seg(seg);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_line_rasterizer_dda: PASS");
    end else begin
      $display("tb_line_rasterizer_dda: FAIL");
    end
    $finish;
  end

endmodule
